// ----- design/ow_pkg.sv -----
// ----------------------------------------------------------------------------
// ow_pkg: shared types and constants of the 1-Wire bus master
// Holds the timer width, the command and register codes, and the structs
// that carry configuration and result items between the modules.
// ----------------------------------------------------------------------------
package ow_pkg;

	localparam int TIMER_BITS = 10;
	localparam int LEN_W      = (TIMER_BITS > 11) ? TIMER_BITS : 11;

	typedef enum logic [1:0] {
		OP_RESET = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW_TIME = 3'd0,
		REG_PRESENCE_WAIT  = 3'd1,
		REG_RESET_TAIL     = 3'd2,
		REG_SLOT_TIME      = 3'd3,
		REG_READ_TAIL      = 3'd4,
		REG_SHORT_LOW      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [7:0] presence_wait;
		logic [9:0] reset_tail;
		logic [7:0] slot_time;
		logic [7:0] read_tail;
		logic [3:0] short_low;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence_line;
	} res_t;

	// A length of zero counts as one tick; the count is cut to the timer width.
	function automatic logic [TIMER_BITS-1:0] timer_load(input logic [10:0] len);
		logic [LEN_W-1:0] v;
		v = (len == 11'd0) ? LEN_W'(1) : LEN_W'(len);
		v = v - LEN_W'(1);
		return v[TIMER_BITS-1:0];
	endfunction

endpackage

// ----- design/one_wire_bus_master.sv -----
// A tick request accepted by the core is registered in its input stage and then
// written into the result queue, which presents it on the result ports in order.
// Throughput: one tick request and one result per clock cycle when the result side
// keeps up; the three-entry result queue absorbs short result stalls.
// Reset: asynchronous and active low; it idles the bus, releases the line, empties
// the queue and restores the default timing registers.
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master
// Runs bus reset with presence check and byte write and read slots, one
// request per microsecond tick, LSB first.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       valid,
	output logic       stall,
	input  logic       cmd_valid,
	input  logic [1:0] operation,
	input  logic [7:0] write_data,
	input  logic       line_in,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       drive_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       presence_line
);
	import ow_pkg::*;

	cfg_t cfg;
	res_t core_res;
	res_t out_res;
	logic push;

	ow_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ow_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (valid && !stall),
		.cmd_valid  (cmd_valid),
		.operation  (operation),
		.write_data (write_data),
		.line_in    (line_in),
		.push       (push),
		.res        (core_res)
	);

	ow_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (core_res),
		.in_flight (push),
		.in_stall  (stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (out_res)
	);

	assign drive_low     = out_res.drive_low;
	assign busy_res      = out_res.busy_res;
	assign done_res      = out_res.done_res;
	assign read_data     = out_res.read_data;
	assign presence_line = out_res.presence_line;

endmodule

// ----- design/ow_cfg.sv -----
// ----------------------------------------------------------------------------
// ow_cfg: timing register file
// Holds the six slot timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ow_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [2:0]    cfg_index,
	input  logic [9:0]    cfg_data,
	output ow_pkg::cfg_t  cfg
);
	import ow_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time <= 10'd480;
			cfg_q.presence_wait  <= 8'd50;
			cfg_q.reset_tail     <= 10'd420;
			cfg_q.slot_time      <= 8'd60;
			cfg_q.read_tail      <= 8'd50;
			cfg_q.short_low      <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RESET_LOW_TIME: cfg_q.reset_low_time <= cfg_data;
				REG_PRESENCE_WAIT:  cfg_q.presence_wait  <= cfg_data[7:0];
				REG_RESET_TAIL:     cfg_q.reset_tail     <= cfg_data;
				REG_SLOT_TIME:      cfg_q.slot_time      <= cfg_data[7:0];
				REG_READ_TAIL:      cfg_q.read_tail      <= cfg_data[7:0];
				REG_SHORT_LOW:      cfg_q.short_low      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/ow_core.sv -----
// ----------------------------------------------------------------------------
// ow_core: bus phase sequencer
// Registers each accepted tick, then advances phase, timer, bit counter and
// shift register by one tick and forms the result item of that tick.
// ----------------------------------------------------------------------------
module ow_core (
	input  logic          clk,
	input  logic          arst_n,
	input  ow_pkg::cfg_t  cfg,
	input  logic          accept,
	input  logic          cmd_valid,
	input  logic [1:0]    operation,
	input  logic [7:0]    write_data,
	input  logic          line_in,
	output logic          push,
	output ow_pkg::res_t  res
);
	import ow_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_SLOT_LOW = 4'd4,
		PH_SLOT_REL = 4'd5
	} phase_t;

	logic                  valid_s1;
	logic                  cmd_s1;
	op_t                   op_s1;
	logic [7:0]            wdata_s1;
	logic                  line_s1;

	phase_t                phase_q, phase_n;
	logic [TIMER_BITS-1:0] timer_q, timer_n;
	logic [2:0]            bitcnt_q, bitcnt_n;
	logic [7:0]            shift_q, shift_n;
	op_t                   kind_q, kind_n;
	logic                  presence_q, presence_n;
	logic [7:0]            rdres_q, rdres_n;
	logic                  done;

	function automatic logic [10:0] low_len(input op_t kind, input logic [7:0] sh,
	                                        input cfg_t c);
		if (kind == OP_WRITE && !sh[0]) begin
			return {3'd0, c.slot_time};
		end
		return {7'd0, c.short_low};
	endfunction

	function automatic logic [10:0] rel_len(input op_t kind, input logic [7:0] sh,
	                                        input cfg_t c);
		if (kind == OP_READ) begin
			return {3'd0, c.read_tail} + 11'd1;
		end
		if (sh[0]) begin
			return {3'd0, c.slot_time};
		end
		return 11'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_valid;
			op_s1    <= op_t'(operation);
			wdata_s1 <= write_data;
			line_s1  <= line_in;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		timer_n    = timer_q;
		bitcnt_n   = bitcnt_q;
		shift_n    = shift_q;
		kind_n     = kind_q;
		presence_n = presence_q;
		rdres_n    = rdres_q;
		done       = 1'b0;
		if (valid_s1) begin
			if (phase_q == PH_IDLE) begin
				if (cmd_s1 && op_s1 != OP_NONE) begin
					kind_n   = op_s1;
					bitcnt_n = 3'd0;
					if (op_s1 == OP_RESET) begin
						phase_n = PH_RST_LOW;
						timer_n = timer_load({1'b0, cfg.reset_low_time});
					end else begin
						shift_n = (op_s1 == OP_WRITE) ? wdata_s1 : 8'd0;
						phase_n = PH_SLOT_LOW;
						timer_n = timer_load(low_len(op_s1, shift_n, cfg));
					end
				end
			end else if (timer_q != '0) begin
				timer_n = timer_q - TIMER_BITS'(1);
			end else begin
				unique case (phase_q)
					PH_RST_LOW: begin
						phase_n = PH_RST_WAIT;
						timer_n = timer_load({3'd0, cfg.presence_wait});
					end
					PH_RST_WAIT: begin
						presence_n = line_s1;
						phase_n    = PH_RST_TAIL;
						timer_n    = timer_load({1'b0, cfg.reset_tail});
					end
					PH_RST_TAIL: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					PH_SLOT_LOW: begin
						phase_n = PH_SLOT_REL;
						timer_n = timer_load(rel_len(kind_q, shift_q, cfg));
						if (kind_q == OP_READ) begin
							shift_n = {line_s1, shift_q[7:1]};
						end
					end
					PH_SLOT_REL: begin
						if (kind_q != OP_READ) begin
							shift_n = {1'b0, shift_q[7:1]};
						end
						if (bitcnt_q == 3'd7) begin
							if (kind_q == OP_READ) begin
								rdres_n = shift_n;
							end
							phase_n = PH_IDLE;
							done    = 1'b1;
						end else begin
							bitcnt_n = bitcnt_q + 3'd1;
							phase_n  = PH_SLOT_LOW;
							timer_n  = timer_load(low_len(kind_q, shift_n, cfg));
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= '0;
			bitcnt_q   <= 3'd0;
			shift_q    <= 8'd0;
			kind_q     <= OP_RESET;
			presence_q <= 1'b1;
			rdres_q    <= 8'd0;
		end else begin
			phase_q    <= phase_n;
			timer_q    <= timer_n;
			bitcnt_q   <= bitcnt_n;
			shift_q    <= shift_n;
			kind_q     <= kind_n;
			presence_q <= presence_n;
			rdres_q    <= rdres_n;
		end
	end

	assign push              = valid_s1;
	assign res.drive_low     = (phase_n == PH_RST_LOW) || (phase_n == PH_SLOT_LOW);
	assign res.busy_res      = (phase_n != PH_IDLE);
	assign res.done_res      = done;
	assign res.read_data     = rdres_n;
	assign res.presence_line = presence_n;

endmodule

// ----- design/ow_outq.sv -----
// ----------------------------------------------------------------------------
// ow_outq: result queue
// Three-entry queue of result items that decouples the tick input from the
// result consumer; its stall to the request side comes from registers only.
// ----------------------------------------------------------------------------
module ow_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ow_pkg::res_t  push_res,
	input  logic          in_flight,
	output logic          in_stall,
	output logic          res_valid,
	input  logic          res_stall,
	output ow_pkg::res_t  res
);
	import ow_pkg::*;

	res_t       mem [3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = res_valid && !res_stall;
	assign res_valid = (cnt_q != 2'd0);
	assign res       = mem[rd_q];
	assign in_stall  = ({1'b0, cnt_q} + {2'b0, in_flight}) >= 3'd3;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == 2'd2) ? 2'd0 : wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= (rd_q == 2'd2) ? 2'd0 : rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- design/ow_checker.sv -----
// ----------------------------------------------------------------------------
// ow_checker: port-level checks of the 1-Wire bus master
// Watches the top-level ports for consistent result items and handshakes.
// ----------------------------------------------------------------------------
module ow_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_stall,
	input logic drive_low,
	input logic busy_res,
	input logic done_res,
	input logic [7:0] read_data
);

	// The line is only pulled low while a command runs.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_low |-> busy_res)
		else $error("drive_low without busy_res");

	// A completing tick is already idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res && !drive_low)
		else $error("done_res while busy");

	// A stalled result holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(read_data) && $stable(done_res))
		else $error("stalled result changed");

endmodule

bind one_wire_bus_master ow_checker u_ow_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.drive_low (drive_low),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.read_data (read_data)
);

// ----- sim/one_wire_bus_master_tb.sv -----
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb: regression bench for the 1-Wire bus master
// Drives tick requests in bursts while the result side stalls on its own
// pattern. A cycle-level predictor of the bus phases, slot timer, bit counter
// and shift register gives the expected result of every accepted tick.
// Covers power-on timing, every command, zero lengths, maximum reset-low and
// presence-wait lengths, commands while busy, random traffic under several
// timing settings, and a long result hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;
	import ow_pkg::*;

	localparam int RESULT_LATENCY = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 4000;

	localparam cfg_t DEFAULT_TIMING = '{reset_low_time: 10'd480, presence_wait: 8'd50,
		reset_tail: 10'd420, slot_time: 8'd60, read_tail: 8'd50, short_low: 4'd1};
	localparam cfg_t BASIC_TIMING = '{reset_low_time: 10'd8, presence_wait: 8'd3,
		reset_tail: 10'd5, slot_time: 8'd4, read_tail: 8'd2, short_low: 4'd2};
	localparam cfg_t MAX_TIMING = '{reset_low_time: 10'd1023, presence_wait: 8'd255,
		reset_tail: 10'd2, slot_time: 8'd255, read_tail: 8'd255, short_low: 4'd15};

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT_LOW, PH_SLOT_REL
	} bus_phase_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;
	logic       valid;
	logic       stall;
	logic       cmd_valid;
	logic [1:0] operation;
	logic [7:0] write_data;
	logic       line_in;
	logic       res_valid;
	logic       res_stall;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       presence_line;

	cfg_t                  timing     = DEFAULT_TIMING;
	bus_phase_t            bus_phase  = PH_IDLE;
	logic [TIMER_BITS-1:0] bus_timer  = '0;
	logic [2:0]            bus_bits   = '0;
	logic [7:0]            bus_shift  = '0;
	op_t                   bus_kind   = OP_RESET;
	logic                  presence   = 1'b1;
	logic [7:0]            last_read  = '0;

	res_t due_results[$];
	res_t want;

	int   fail_count      = 0;
	int   ticks_sent      = 0;
	int   results_checked = 0;
	int   done_pulses     = 0;
	int   settings_loaded = 0;
	int   cmd_count[4]    = '{0, 0, 0, 0};
	int   burst_left      = 0;
	int   quiet_cycles    = 0;
	bit   hold_request    = 1'b0;

	one_wire_bus_master dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid        (valid),
		.stall        (stall),
		.cmd_valid    (cmd_valid),
		.operation    (operation),
		.write_data   (write_data),
		.line_in      (line_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.drive_low    (drive_low),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_data    (read_data),
		.presence_line(presence_line)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [TIMER_BITS-1:0] count_for(input int unsigned len);
		return (len == 0) ? '0 : TIMER_BITS'(len - 1);
	endfunction

	function automatic int unsigned slot_low_len();
		if (bus_kind == OP_WRITE && !bus_shift[0])
			return 32'(timing.slot_time);
		return 32'(timing.short_low);
	endfunction

	function automatic int unsigned slot_release_len();
		if (bus_kind == OP_READ)
			return 1 + timing.read_tail;
		if (bus_shift[0])
			return 32'(timing.slot_time);
		return 1;
	endfunction

	// Advances the bus by one tick and returns what the block shows afterwards.
	function automatic res_t advance_bus(input logic cv, input op_t op, input logic [7:0] wd,
			input logic ln);
		res_t r;
		r.done_res = 1'b0;
		if (bus_phase == PH_IDLE) begin
			if (cv && op != OP_NONE) begin
				cmd_count[op]++;
				bus_kind = op;
				bus_bits = '0;
				if (op == OP_RESET) begin
					bus_phase = PH_RST_LOW;
					bus_timer = count_for(32'(timing.reset_low_time));
				end else begin
					bus_shift = (op == OP_WRITE) ? wd : 8'h00;
					bus_phase = PH_SLOT_LOW;
					bus_timer = count_for(slot_low_len());
				end
			end
		end else if (bus_timer != '0) begin
			bus_timer = bus_timer - TIMER_BITS'(1);
		end else begin
			case (bus_phase)
				PH_RST_LOW: begin
					bus_phase = PH_RST_WAIT;
					bus_timer = count_for(32'(timing.presence_wait));
				end
				PH_RST_WAIT: begin
					presence  = ln;
					bus_phase = PH_RST_TAIL;
					bus_timer = count_for(32'(timing.reset_tail));
				end
				PH_RST_TAIL: begin
					bus_phase  = PH_IDLE;
					r.done_res = 1'b1;
				end
				PH_SLOT_LOW: begin
					bus_phase = PH_SLOT_REL;
					bus_timer = count_for(slot_release_len());
					if (bus_kind == OP_READ)
						bus_shift = {ln, bus_shift[7:1]};
				end
				PH_SLOT_REL: begin
					if (bus_kind != OP_READ)
						bus_shift = bus_shift >> 1;
					if (bus_bits == 3'd7) begin
						if (bus_kind == OP_READ)
							last_read = bus_shift;
						bus_phase  = PH_IDLE;
						r.done_res = 1'b1;
					end else begin
						bus_bits  = bus_bits + 3'd1;
						bus_phase = PH_SLOT_LOW;
						bus_timer = count_for(slot_low_len());
					end
				end
				default: bus_phase = PH_IDLE;
			endcase
		end
		if (r.done_res)
			done_pulses++;
		r.drive_low     = (bus_phase == PH_RST_LOW || bus_phase == PH_SLOT_LOW);
		r.busy_res      = (bus_phase != PH_IDLE);
		r.read_data     = last_read;
		r.presence_line = presence;
		return r;
	endfunction

	task automatic send_tick(input logic cv, input op_t op, input logic [7:0] wd, input logic ln);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 16);
		end
		burst_left--;
		valid      <= 1'b1;
		cmd_valid  <= cv;
		operation  <= op;
		write_data <= wd;
		line_in    <= ln;
		@(posedge clk);
		while (stall)
			@(posedge clk);
		due_results.push_back(advance_bus(cv, op, wd, ln));
		ticks_sent++;
	endtask

	// The line follows the pattern bit chosen by the current slot number, so a
	// read returns the pattern and a bus reset samples its lowest bit.
	task automatic run_command(input op_t op, input logic [7:0] wd, input logic [7:0] pattern,
			input bit noise);
		send_tick(1'b1, op, wd, pattern[bus_bits]);
		while (bus_phase != PH_IDLE)
			send_tick(noise && $urandom_range(0, 1), op_t'(2'($urandom)), 8'($urandom),
				pattern[bus_bits]);
	endtask

	task automatic settle();
		while (bus_phase != PH_IDLE)
			send_tick(1'b0, OP_NONE, 8'($urandom), 1'($urandom));
		valid <= 1'b0;
		burst_left = 0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [9:0] word);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
	endtask

	// Bits above a register's width carry random values and must be dropped.
	task automatic load_timing(input cfg_t c);
		settle();
		write_reg(REG_RESET_LOW_TIME, c.reset_low_time);
		write_reg(REG_PRESENCE_WAIT, {2'($urandom), c.presence_wait});
		write_reg(REG_RESET_TAIL, c.reset_tail);
		write_reg(REG_SLOT_TIME, {2'($urandom), c.slot_time});
		write_reg(REG_READ_TAIL, {2'($urandom), c.read_tail});
		write_reg(REG_SHORT_LOW, {6'($urandom), c.short_low});
		cfg_write <= 1'b0;
		timing = c;
		settings_loaded++;
	endtask

	function automatic int unsigned short_len(input int unsigned hi);
		return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, hi);
	endfunction

	function automatic cfg_t pick_timing();
		cfg_t c;
		c.reset_low_time = 10'(short_len(24));
		c.presence_wait  = 8'(short_len(10));
		c.reset_tail     = 10'(short_len(20));
		c.slot_time      = 8'(short_len(12));
		c.read_tail      = 8'(short_len(8));
		c.short_low      = 4'(short_len(15));
		return c;
	endfunction

	task automatic test_power_on_timing();
		run_command(OP_READ, 8'h00, 8'h69, 1'b0);
	endtask

	task automatic test_basic_commands();
		load_timing(BASIC_TIMING);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		run_command(OP_RESET, 8'hFF, 8'hFF, 1'b0);
		run_command(OP_WRITE, 8'h00, 8'h00, 1'b0);
		run_command(OP_WRITE, 8'hFF, 8'hFF, 1'b0);
		run_command(OP_READ, 8'h00, 8'hFF, 1'b0);
		run_command(OP_READ, 8'hFF, 8'h00, 1'b0);
		run_command(OP_READ, 8'h5A, 8'hA5, 1'b0);
		run_command(OP_NONE, 8'hFF, 8'hFF, 1'b0);
		run_command(OP_WRITE, 8'hC3, 8'h3C, 1'b1);
		run_command(OP_RESET, 8'h81, 8'h7E, 1'b1);
	endtask

	task automatic test_zero_lengths();
		load_timing('0);
		run_command(OP_RESET, 8'h00, 8'h00, 1'b0);
		run_command(OP_WRITE, 8'h96, 8'hFF, 1'b0);
		run_command(OP_READ, 8'h00, 8'h69, 1'b1);
	endtask

	task automatic test_long_lengths();
		load_timing(MAX_TIMING);
		run_command(OP_RESET, 8'h00, 8'h01, 1'b1);
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		int unsigned pick;
		op_t         op;
		for (int s = 0; s < 3; s++) begin
			load_timing(pick_timing());
			stop_at = ticks_sent + 120;
			while (ticks_sent < stop_at) begin
				repeat ($urandom_range(0, 3))
					send_tick(1'b0, op_t'(2'($urandom)), 8'($urandom), 1'($urandom));
				pick = $urandom_range(0, 19);
				if (pick == 0)
					op = OP_NONE;
				else if (pick < 7)
					op = OP_RESET;
				else if (pick < 13)
					op = OP_WRITE;
				else
					op = OP_READ;
				run_command(op, 8'($urandom), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic test_result_hold_off();
		load_timing(BASIC_TIMING);
		hold_request = 1'b1;
		while (hold_request)
			send_tick(bus_phase == PH_IDLE, op_t'(2'($urandom_range(0, 2))), 8'($urandom),
				1'($urandom));
		repeat (50)
			send_tick(bus_phase == PH_IDLE, op_t'(2'($urandom_range(0, 2))), 8'($urandom),
				1'($urandom));
	endtask

	initial begin : result_stall_pattern
		int run_left;
		int pct;
		run_left = 0;
		pct      = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_request = 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(20, 200);
					case ($urandom_range(0, 2))
						0: pct = 0;
						1: pct = 20;
						default: pct = 70;
					endcase
				end
				run_left--;
				res_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				$error("result with no request waiting");
				fail_count++;
			end else begin
				want = due_results.pop_front();
				check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
				check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
				check_field("done_res", 8'(want.done_res), 8'(done_res));
				check_field("read_data", want.read_data, read_data);
				check_field("presence_line", 8'(want.presence_line), 8'(presence_line));
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (valid && !stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
				$display("one_wire_bus_master regression: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= REG_RESET_LOW_TIME;
		cfg_data   <= '0;
		valid      <= 1'b0;
		cmd_valid  <= 1'b0;
		operation  <= OP_RESET;
		write_data <= '0;
		line_in    <= 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_timing();
		test_basic_commands();
		test_zero_lengths();
		test_long_lengths();
		test_random_traffic();
		test_result_hold_off();
		settle();

		$display("Sent %0d ticks under %0d timing settings: %0d bus resets, %0d writes, %0d reads.",
			ticks_sent, settings_loaded, cmd_count[OP_RESET], cmd_count[OP_WRITE],
			cmd_count[OP_READ]);
		$display("Checked %0d results, %0d of them command completions.",
			results_checked, done_pulses);
		if (fail_count == 0)
			$display("one_wire_bus_master regression: pass");
		else
			$display("one_wire_bus_master regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
design/ow_pkg.sv
design/ow_cfg.sv
design/ow_core.sv
design/ow_outq.sv
design/one_wire_bus_master.sv
design/ow_checker.sv
sim/one_wire_bus_master_tb.sv
